// ===== design/nfbsa_pkg.sv =====
// Package for the next-fit bitmap slot allocator.
// Holds the sequencer state type, field widths and mode codes.
// No dependencies.
package nfbsa_pkg;

    localparam int IDX_W   = 10;  // slot index width
    localparam int CNT_W   = 11;  // used-slot count width
    localparam int TDATA_W = 16;  // stream data width, whole bytes

    localparam logic MODE_ALLOC   = 1'b0;
    localparam logic MODE_RELEASE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_REL,
        ST_OUT
    } nfbsa_state_t;

endpackage

// ===== design/nfbsa_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module nfbsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                                     aclk,
    input  logic                                     we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/next_fit_bitmap_slot_allocator.sv =====
// Next-fit bitmap slot allocator, top level.
// Uses nfbsa_pkg (state type, widths, mode codes) and nfbsa_ram (bitmap rows).
//
// The pool of min(SLOTS_PER_ROW * ROW_COUNT, 1024) slots is held as a bitmap
// in a RAM of ROW_COUNT rows, SLOTS_PER_ROW bits each (1 = used). An allocate
// item moves the cursor one slot forward, with wrap, then scans forward for
// the first free slot, marks it used and returns its index; the first grant
// after reset is slot 1. When the pool is full the item returns index 0 with
// success 0 and nothing changes. A release item clears the bit of the given
// slot and echoes the index; releasing a free slot or an index past the pool
// returns success 0 and changes nothing. Every item gives exactly one result.
// Timing: the block works on one item at a time; s_tready is high only while
// it waits for an item. An allocate is accepted, then visits bitmap rows in
// the scan (one RAM read and one find-first-free per row, at most
// ROW_COUNT + 1 rows), and then presents its result. A release splits the
// index into row and bit with a constant reciprocal multiply at accept and a
// subtract in the next cycle, then does a read-check of the bit. A full-pool
// allocate or out-of-pool release goes straight to its result. Each result
// is held until m_tready takes it.
// After reset a clearing pass writes zero into every bitmap row, during
// which no item is accepted.
module next_fit_bitmap_slot_allocator #(
    parameter int SLOTS_PER_ROW = 32,
    parameter int ROW_COUNT     = 32
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: [0] mode, [10:1] slot_index, rest zero
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [nfbsa_pkg::TDATA_W-1:0] s_tdata,
    // m_tdata: [9:0] granted_index, [10] success, rest zero
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [nfbsa_pkg::TDATA_W-1:0] m_tdata
);

    localparam int IDX_W    = nfbsa_pkg::IDX_W;
    localparam int CNT_W    = nfbsa_pkg::CNT_W;
    localparam int RAW      = SLOTS_PER_ROW * ROW_COUNT;
    localparam int POOL     = (RAW > 1024) ? 1024 : RAW;
    localparam int LAST_ROW = (POOL - 1) / SLOTS_PER_ROW;
    localparam int BW       = $clog2(SLOTS_PER_ROW);
    localparam int RW       = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam int PAD_W    = nfbsa_pkg::TDATA_W - IDX_W - 1;
    // row = (index * RECIP) >> DIV_SH, exact for every 10-bit index
    localparam int DIV_SH   = IDX_W + BW;
    localparam int RECIP    = ((1 << DIV_SH) + SLOTS_PER_ROW - 1) / SLOTS_PER_ROW;

    // ---- state -------------------------------------------------------------
    nfbsa_pkg::nfbsa_state_t state_reg, state_next;

    // cursor: row, bit within row, linear index, linear index of row's bit 0
    logic [RW-1:0]    cur_row_reg,  cur_row_next;
    logic [BW-1:0]    cur_bit_reg,  cur_bit_next;
    logic [IDX_W-1:0] cur_idx_reg,  cur_idx_next;
    logic [CNT_W-1:0] cur_base_reg, cur_base_next;
    logic [CNT_W-1:0] used_count_reg, used_count_next;

    // working row/bit: scan position, release target, clear pass counter
    logic [RW-1:0]    work_row_reg,  work_row_next;
    logic [BW-1:0]    work_bit_reg,  work_bit_next;
    logic [CNT_W-1:0] work_base_reg, work_base_next;

    // release index held while its bit position is worked out
    logic [IDX_W-1:0] div_num_reg, div_num_next;

    // result
    logic [IDX_W-1:0] res_index_reg, res_index_next;
    logic             res_ok_reg,    res_ok_next;

    // bitmap RAM
    logic                     ram_we;
    logic [RW-1:0]            ram_waddr;
    logic [SLOTS_PER_ROW-1:0] ram_wdata;
    logic [SLOTS_PER_ROW-1:0] ram_rdata;

    nfbsa_ram #(
        .WIDTH (SLOTS_PER_ROW),
        .DEPTH (ROW_COUNT)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (work_row_next),
        .rdata (ram_rdata)
    );

    // ---- input fields ------------------------------------------------------
    logic             in_mode;
    logic [IDX_W-1:0] in_slot;
    assign in_mode = s_tdata[0];
    assign in_slot = s_tdata[IDX_W:1];

    // ---- find first free bit in the row being scanned ----------------------
    logic [SLOTS_PER_ROW-1:0] free_vec;
    logic                     found;
    logic [BW-1:0]            found_bit;
    logic [SLOTS_PER_ROW-1:0] found_mask;
    logic [CNT_W-1:0]         grant_idx;

    always_comb begin
        for (int i = 0; i < SLOTS_PER_ROW; i++) begin
            free_vec[i] = !ram_rdata[i]
                          && (BW'(i) >= work_bit_reg)
                          && ((work_base_reg + CNT_W'(i)) < CNT_W'(POOL));
        end
        found     = 1'b0;
        found_bit = '0;
        // walk from the top so the lowest free bit wins
        for (int i = SLOTS_PER_ROW - 1; i >= 0; i--) begin
            if (free_vec[i]) begin
                found     = 1'b1;
                found_bit = BW'(i);
            end
        end
    end

    assign found_mask = SLOTS_PER_ROW'(1) << found_bit;
    assign grant_idx  = work_base_reg + CNT_W'(found_bit);

    // mask of the release target bit
    logic [SLOTS_PER_ROW-1:0] rel_mask;
    logic                     rel_hit;
    assign rel_mask = SLOTS_PER_ROW'(1) << work_bit_reg;
    assign rel_hit  = |(ram_rdata & rel_mask);

    // ---- release index split: row by reciprocal multiply, bit by subtract --
    logic [31:0]      rel_prod;
    logic [IDX_W-1:0] rel_row;
    logic [IDX_W-1:0] rel_rem;

    assign rel_prod = 32'(in_slot) * 32'(RECIP);
    assign rel_row  = rel_prod[DIV_SH +: IDX_W];
    assign rel_rem  = div_num_reg - IDX_W'(work_row_reg) * IDX_W'(SLOTS_PER_ROW);

    // ---- sequencer ---------------------------------------------------------
    always_comb begin
        state_next      = state_reg;
        cur_row_next    = cur_row_reg;
        cur_bit_next    = cur_bit_reg;
        cur_idx_next    = cur_idx_reg;
        cur_base_next   = cur_base_reg;
        used_count_next = used_count_reg;
        work_row_next   = work_row_reg;
        work_bit_next   = work_bit_reg;
        work_base_next  = work_base_reg;
        div_num_next    = div_num_reg;
        res_index_next  = res_index_reg;
        res_ok_next     = res_ok_reg;
        ram_we          = 1'b0;
        ram_waddr       = work_row_reg;
        ram_wdata       = '0;

        unique case (state_reg)
            nfbsa_pkg::ST_CLEAR: begin
                // zero one row per cycle
                ram_we = 1'b1;
                if (work_row_reg == RW'(ROW_COUNT - 1)) begin
                    work_row_next = '0;
                    state_next    = nfbsa_pkg::ST_IDLE;
                end else begin
                    work_row_next = work_row_reg + RW'(1);
                end
            end

            nfbsa_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_mode == nfbsa_pkg::MODE_ALLOC) begin
                        if (used_count_reg == CNT_W'(POOL)) begin
                            // pool full: no search
                            res_index_next = '0;
                            res_ok_next    = 1'b0;
                            state_next     = nfbsa_pkg::ST_OUT;
                        end else begin
                            // advance cursor by one, start scanning there
                            if (cur_idx_reg == IDX_W'(POOL - 1)) begin
                                work_row_next  = '0;
                                work_bit_next  = '0;
                                work_base_next = '0;
                            end else if (cur_bit_reg == BW'(SLOTS_PER_ROW - 1)) begin
                                work_row_next  = cur_row_reg + RW'(1);
                                work_bit_next  = '0;
                                work_base_next = cur_base_reg + CNT_W'(SLOTS_PER_ROW);
                            end else begin
                                work_row_next  = cur_row_reg;
                                work_bit_next  = cur_bit_reg + BW'(1);
                                work_base_next = cur_base_reg;
                            end
                            state_next = nfbsa_pkg::ST_SCAN;
                        end
                    end else begin
                        res_index_next = in_slot;
                        if ({1'b0, in_slot} >= CNT_W'(POOL)) begin
                            res_ok_next = 1'b0;
                            state_next  = nfbsa_pkg::ST_OUT;
                        end else begin
                            // start the row read now, find the bit next cycle
                            div_num_next  = in_slot;
                            work_row_next = rel_row[RW-1:0];
                            state_next    = nfbsa_pkg::ST_DIV;
                        end
                    end
                end
            end

            nfbsa_pkg::ST_DIV: begin
                // bit within the row: index minus the row's first slot
                work_bit_next = rel_rem[BW-1:0];
                state_next    = nfbsa_pkg::ST_REL;
            end

            nfbsa_pkg::ST_SCAN: begin
                if (found) begin
                    // mark used, move cursor onto the grant
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata | found_mask;
                    cur_row_next    = work_row_reg;
                    cur_bit_next    = found_bit;
                    cur_idx_next    = grant_idx[IDX_W-1:0];
                    cur_base_next   = work_base_reg;
                    used_count_next = used_count_reg + CNT_W'(1);
                    res_index_next  = grant_idx[IDX_W-1:0];
                    res_ok_next     = 1'b1;
                    state_next      = nfbsa_pkg::ST_OUT;
                end else if (work_row_reg == RW'(LAST_ROW)) begin
                    // wrap to the first row
                    work_row_next  = '0;
                    work_bit_next  = '0;
                    work_base_next = '0;
                end else begin
                    work_row_next  = work_row_reg + RW'(1);
                    work_bit_next  = '0;
                    work_base_next = work_base_reg + CNT_W'(SLOTS_PER_ROW);
                end
            end

            nfbsa_pkg::ST_REL: begin
                if (rel_hit) begin
                    ram_we          = 1'b1;
                    ram_wdata       = ram_rdata & ~rel_mask;
                    used_count_next = used_count_reg - CNT_W'(1);
                end
                res_ok_next = rel_hit;
                state_next  = nfbsa_pkg::ST_OUT;
            end

            nfbsa_pkg::ST_OUT: begin
                if (m_tready) begin
                    state_next = nfbsa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = nfbsa_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= nfbsa_pkg::ST_CLEAR;
            cur_row_reg    <= '0;
            cur_bit_reg    <= '0;
            cur_idx_reg    <= '0;
            cur_base_reg   <= '0;
            used_count_reg <= '0;
            work_row_reg   <= '0;
        end else begin
            state_reg      <= state_next;
            cur_row_reg    <= cur_row_next;
            cur_bit_reg    <= cur_bit_next;
            cur_idx_reg    <= cur_idx_next;
            cur_base_reg   <= cur_base_next;
            used_count_reg <= used_count_next;
            work_row_reg   <= work_row_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge aclk) begin
        work_bit_reg  <= work_bit_next;
        work_base_reg <= work_base_next;
        div_num_reg   <= div_num_next;
        res_index_reg <= res_index_next;
        res_ok_reg    <= res_ok_next;
    end

    // ---- ports -------------------------------------------------------------
    assign s_tready = (state_reg == nfbsa_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == nfbsa_pkg::ST_OUT);
    assign m_tdata  = {PAD_W'(0), res_ok_reg, res_index_reg};

    // ---- assertions --------------------------------------------------------
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input accepted while a result is pending");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        used_count_reg <= CNT_W'(POOL))
        else $error("used count exceeds pool size");

    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        {1'b0, cur_idx_reg} < CNT_W'(POOL))
        else $error("cursor outside the pool");

    a_count_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (used_count_reg != $past(used_count_reg))
        |-> ($past(state_reg) == nfbsa_pkg::ST_SCAN
             || $past(state_reg) == nfbsa_pkg::ST_REL))
        else $error("used count changed outside allocate or release");

    a_grant_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == nfbsa_pkg::ST_SCAN && found) |=> (m_tvalid && res_ok_reg))
        else $error("found slot not reported as a grant");

endmodule
